/* hw/rtl/dmc_pkg.sv */
// Shared types, constants and helpers for the direct-mapped cache hit counter.
package dmc_pkg;

    localparam int unsigned DEF_MAX_LINES = 1024;

    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned CNT_W       = 32;
    localparam int unsigned CFG_W       = 4;
    localparam int unsigned CFG_INDEX_W = 2;
    // index_bits tops out at 15, so a masked set select never needs more bits
    localparam int unsigned MASK_W      = 15;

    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_OFFSET = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_INDEX_BITS   = CFG_INDEX_W'(1);

    localparam logic [CFG_W-1:0] RST_BLOCK_OFFSET = CFG_W'(5);
    localparam logic [CFG_W-1:0] RST_INDEX_BITS   = CFG_W'(10);

    // Classified request handed from the front end to the back end
    typedef struct packed {
        logic [MASK_W-1:0] set_sel;
        logic [ADDR_W-1:0] block;
    } req_t;

    // One entry of the line store
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] block;
    } line_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == '1) ? v : v + CNT_W'(1);
    endfunction

endpackage

/* hw/rtl/dmc_front.sv */
// Front end: configuration registers and block address / set select classification.
module dmc_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [dmc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dmc_pkg::CFG_W-1:0]      cfg_data,
    input  logic [dmc_pkg::ADDR_W-1:0]     address,
    output dmc_pkg::req_t                  req
);
    import dmc_pkg::*;

    logic [CFG_W-1:0]  offset_reg;
    logic [CFG_W-1:0]  offset_next;
    logic [CFG_W-1:0]  idx_bits_reg;
    logic [CFG_W-1:0]  idx_bits_next;
    logic [ADDR_W-1:0] block;
    logic [MASK_W:0]   mask_full;

    always_comb
    begin
        offset_next   = offset_reg;
        idx_bits_next = idx_bits_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_BLOCK_OFFSET: offset_next   = cfg_data;
                REG_INDEX_BITS:   idx_bits_next = cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= RST_BLOCK_OFFSET;
            idx_bits_reg <= RST_INDEX_BITS;
        end
        else
        begin
            offset_reg   <= offset_next;
            idx_bits_reg <= idx_bits_next;
        end
    end

    // Drop the byte offset, then keep only the configured index bits
    assign block     = address >> offset_reg;
    assign mask_full = ((MASK_W+1)'(1) << idx_bits_reg) - (MASK_W+1)'(1);

    assign req.block   = block;
    assign req.set_sel = block[MASK_W-1:0] & mask_full[MASK_W-1:0];

endmodule

/* hw/rtl/dmc_queue.sv */
// Two-entry request queue between the front end and the back end.
module dmc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dmc_pkg::req_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output dmc_pkg::req_t head
);
    import dmc_pkg::*;

    req_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* hw/rtl/dmc_back.sv */
// Back end: line store, post-reset clearing pass, tag compare and saturating counters.
module dmc_back #(
    parameter int unsigned MAX_LINES = dmc_pkg::DEF_MAX_LINES
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dmc_pkg::req_t            head,
    input  logic                     head_valid,
    output logic                     pop,
    output logic                     clearing,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     hit,
    output logic [dmc_pkg::CNT_W-1:0] hit_count,
    output logic [dmc_pkg::CNT_W-1:0] access_count
);
    import dmc_pkg::*;

    localparam int unsigned IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam logic [IDX_W-1:0] LINE_MASK = IDX_W'(MAX_LINES - 1);
    localparam logic [IDX_W-1:0] LAST_LINE = IDX_W'(MAX_LINES - 1);

    line_t             mem [MAX_LINES];

    logic              clr_busy_reg;
    logic              clr_busy_next;
    logic [IDX_W-1:0]  clr_idx_reg;
    logic [IDX_W-1:0]  clr_idx_next;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [IDX_W-1:0]  s1_line_reg;
    logic [ADDR_W-1:0] s1_block_reg;
    line_t             rd_reg;
    logic              fwd_reg;
    logic [ADDR_W-1:0] fwd_block_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              hit_reg;
    logic [CNT_W-1:0]  hit_cnt_reg;
    logic [CNT_W-1:0]  hit_cnt_next;
    logic [CNT_W-1:0]  acc_cnt_reg;
    logic [CNT_W-1:0]  acc_cnt_next;

    logic [IDX_W-1:0]  head_line;
    logic              adv;
    logic              hit_now;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    line_t             wr_data;

    // Reduce the set select to the store depth
    assign head_line = IDX_W'(head.set_sel) & LINE_MASK;

    assign adv  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign pop  = head_valid && !clr_busy_reg && (!s1_valid_reg || adv);

    // A same-line write in the read cycle takes precedence over the stale read
    assign hit_now = fwd_reg ? (fwd_block_reg == s1_block_reg)
                             : (rd_reg.valid && (rd_reg.block == s1_block_reg));

    always_comb
    begin
        wr_en         = clr_busy_reg || adv;
        wr_addr       = clr_busy_reg ? clr_idx_reg : s1_line_reg;
        wr_data.valid = !clr_busy_reg;
        wr_data.block = s1_block_reg;

        clr_busy_next = clr_busy_reg && (clr_idx_reg != LAST_LINE);
        clr_idx_next  = clr_busy_reg ? clr_idx_reg + IDX_W'(1) : clr_idx_reg;

        s1_valid_next = pop || (s1_valid_reg && !adv);

        out_valid_next = adv || (out_valid_reg && out_stall);
        hit_cnt_next   = hit_cnt_reg;
        acc_cnt_next   = acc_cnt_reg;
        if (adv)
        begin
            acc_cnt_next = sat_inc(acc_cnt_reg);
            if (hit_now)
                hit_cnt_next = sat_inc(hit_cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hit_cnt_reg   <= '0;
            acc_cnt_reg   <= '0;
        end
        else
        begin
            clr_busy_reg  <= clr_busy_next;
            clr_idx_reg   <= clr_idx_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            hit_cnt_reg   <= hit_cnt_next;
            acc_cnt_reg   <= acc_cnt_next;
        end
    end

    // Line store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (pop)
            rd_reg <= mem[head_line];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_line_reg   <= head_line;
            s1_block_reg  <= head.block;
            fwd_reg       <= adv && (s1_line_reg == head_line);
            fwd_block_reg <= s1_block_reg;
        end
        if (adv)
            hit_reg <= hit_now;
    end

    assign clearing     = clr_busy_reg;
    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign hit_count    = hit_cnt_reg;
    assign access_count = acc_cnt_reg;

endmodule

/* hw/rtl/direct_mapped_cache_hit_counter_top.sv */
// Top level of the direct-mapped cache hit counter.
//
// Usage:
//   Input channel (in_valid / in_stall / address) carries one access address per
//   request. A request is taken on a rising edge with in_valid high and
//   in_stall low. Output channel (out_valid / out_stall / hit, hit_count,
//   access_count) returns one result per request, in order; the counts already
//   include that request.
//   Configuration: cfg_write with cfg_index 0 sets block_offset_bits, index 1
//   sets index_bits; other indexes are ignored. Write only while idle.
// Timing:
//   Sustained throughput is one request per cycle while out_stall is low: the
//   front end classifies the address as it enters a two-entry queue, and the
//   back end reads the line store into a register, then compares and writes
//   back from the staged request, forwarding a same-line write to the next read.
// Reset:
//   Counters clear and the line store is swept one line per cycle to clear the
//   valid bits; in_stall stays high during the sweep.
// Stall:
//   When out_stall holds the result, the back end holds its staged request and
//   the queue fills; once full, in_stall rises until the receiver drains.
module direct_mapped_cache_hit_counter_top #(
    parameter int unsigned MAX_LINES = dmc_pkg::DEF_MAX_LINES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [dmc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dmc_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [dmc_pkg::ADDR_W-1:0]      address,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            hit,
    output logic [dmc_pkg::CNT_W-1:0]       hit_count,
    output logic [dmc_pkg::CNT_W-1:0]       access_count
);
    import dmc_pkg::*;

    req_t front_req;
    req_t q_head;
    logic q_full;
    logic q_not_empty;
    logic q_push;
    logic q_pop;
    logic clearing;

    // Hold off new requests while the queue is full or the sweep runs
    assign in_stall = q_full || clearing;
    assign q_push   = in_valid && !in_stall;

    dmc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .address   (address),
        .req       (front_req)
    );

    dmc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_req),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    dmc_back #(
        .MAX_LINES (MAX_LINES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .head_valid   (q_not_empty),
        .pop          (q_pop),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .hit_count    (hit_count),
        .access_count (access_count)
    );

endmodule

/* tb/sv/direct_mapped_cache_hit_counter_top_test.sv */
// Self-checking testbench for the direct-mapped cache hit counter top level.
module direct_mapped_cache_hit_counter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dmc_pkg::*;

    localparam int unsigned LINES          = DEF_MAX_LINES;
    localparam int unsigned NUM_DIRECTED   = 17;
    localparam int unsigned NUM_FIXED      = 10;
    localparam int unsigned NUM_PHASES     = 12;
    localparam int unsigned PHASE_ITEMS    = 157;
    localparam int unsigned HISTORY_DEPTH  = 32;
    // Settling time for the pipeline after the last result has come back.
    localparam int unsigned DRAIN_CYCLES   = 6;
    // Long enough for the input queue to fill and in_stall to rise.
    localparam int unsigned LONG_HOLD      = 400;
    // Covers the line-store sweep after reset, the long hold and random stalls.
    localparam int unsigned WATCHDOG_LIMIT = 6000;
    localparam int unsigned MAX_PRINTED    = 40;

    // Writes to these indexes must leave both registers untouched.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = CFG_INDEX_W'(3);

    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

    typedef struct {
        logic             hit;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] accesses;
    } lookup_outcome_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_write    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]       cfg_data     = '0;
    logic                   in_valid     = 1'b0;
    logic                   in_stall;
    logic [ADDR_W-1:0]      address      = '0;
    logic                   out_valid;
    logic                   out_stall    = 1'b0;
    logic                   hit;
    logic [CNT_W-1:0]       hit_count;
    logic [CNT_W-1:0]       access_count;

    direct_mapped_cache_hit_counter_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .address      (address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .hit_count    (hit_count),
        .access_count (access_count)
    );

    // Shadow copy of the cache: registers, tag store, valid bits, counters.
    logic [CFG_W-1:0]  shadow_offset = RST_BLOCK_OFFSET;
    logic [CFG_W-1:0]  shadow_index  = RST_INDEX_BITS;
    logic [ADDR_W-1:0] shadow_block [LINES];
    bit                shadow_valid [LINES];
    logic [CNT_W-1:0]  shadow_hits     = '0;
    logic [CNT_W-1:0]  shadow_accesses = '0;

    logic [ADDR_W-1:0] pending_addr [$];
    lookup_outcome_t   predicted_lookups [$];
    logic [ADDR_W-1:0] recent_addr [$];

    int unsigned issued_items   = 0;
    int unsigned accepted_items = 0;
    int unsigned results_seen   = 0;
    int unsigned hits_observed  = 0;
    int unsigned settings_run   = 1;
    int unsigned error_count    = 0;
    int unsigned idle_cycles    = 0;
    bit          long_hold_req  = 1'b0;

    // Corners at the reset setting (32-byte blocks, 1024 lines): repeats,
    // same block at another offset, a conflict on line 0, back-to-back
    // same-line accesses and all-ones / alternating address patterns.
    logic [ADDR_W-1:0] directed_addr [NUM_DIRECTED] = '{
        32'h0000_0000, 32'h0000_0000, 32'h0000_001F, 32'h0000_0020,
        32'h0000_8000, 32'h0000_0000, 32'h0000_0040, 32'h0000_8040,
        32'h0000_0040, 32'hFFFF_FFFF, 32'hFFFF_FFE0, 32'hAAAA_AAAA,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h0000_001F
    };

    // Register settings per phase, extremes included; the last phases draw
    // random values. The return to 5/10 reuses lines left from earlier phases.
    logic [CFG_W-1:0] sched_offset [NUM_FIXED] = '{0, 15, 12, 0, 15, 3, 13, 2, 14, 5};
    logic [CFG_W-1:0] sched_index  [NUM_FIXED] = '{0, 15, 10, 10, 0, 4, 11, 10, 12, 10};

    initial begin
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTED)
            $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, what);
        error_count++;
    endtask

    // Look the address up in the shadow cache, fill the line, bump counters.
    function automatic lookup_outcome_t predict_access(input logic [ADDR_W-1:0] addr);
        lookup_outcome_t   res;
        logic [ADDR_W-1:0] blk;
        logic [ADDR_W-1:0] mask;
        int unsigned       line;
        blk  = addr >> shadow_offset;
        mask = (ADDR_W'(1) << shadow_index) - ADDR_W'(1);
        line = (blk & mask) % LINES;
        res.hit = shadow_valid[line] && (shadow_block[line] == blk);
        if (shadow_accesses != '1)
            shadow_accesses = shadow_accesses + CNT_W'(1);
        if (res.hit && shadow_hits != '1)
            shadow_hits = shadow_hits + CNT_W'(1);
        shadow_block[line] = blk;
        shadow_valid[line] = 1'b1;
        res.hits     = shadow_hits;
        res.accesses = shadow_accesses;
        return res;
    endfunction

    // Write one register; the write enable is high for exactly one edge.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Hold until every queued request is taken and every result is back.
    task automatic wait_for_drain();
        while (accepted_items != issued_items || predicted_lookups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Request driver: bursts of random length separated by random gaps.
    // Change the payload only when nothing is offered or the offer was taken.
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid   <= 1'b0;
            address    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!in_valid || !in_stall) begin
            if (gap_left != 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_addr.size() != 0) begin
                in_valid <= 1'b1;
                address  <= pending_addr.pop_front();
                if (burst_left <= 1) begin
                    // Mix short bursts with long stretches that never idle.
                    burst_left <= ($urandom_range(3) == 0) ? $urandom_range(200, 60)
                                                           : $urandom_range(24, 1);
                    gap_left   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(12, 1);
                end
                else begin
                    burst_left <= burst_left - 1;
                end
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: stall by a mode that is redrawn at random from time to time,
    // plus one long hold-off so the block backs up into in_stall.
    rx_mode_t    rx_mode   = RX_FREE;
    int unsigned mode_left = 100;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_mode   <= RX_FREE;
            mode_left <= 100;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else begin
            if (hold_left != 0) begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (long_hold_req && !hold_done) begin
                out_stall <= 1'b1;
                hold_left <= LONG_HOLD;
                hold_done <= 1'b1;
            end
            else begin
                case (rx_mode)
                    RX_FREE:  out_stall <= 1'b0;
                    RX_LIGHT: out_stall <= ($urandom_range(3) == 0);
                    RX_HEAVY: out_stall <= ($urandom_range(9) < 7);
                    default:  out_stall <= ~out_stall;
                endcase
            end
            if (mode_left == 0) begin
                rx_mode   <= rx_mode_t'($urandom_range(3));
                mode_left <= $urandom_range(300, 40);
            end
            else begin
                mode_left <= mode_left - 1;
            end
        end
    end

    // Scoreboard: check a result against the oldest prediction before
    // pushing the prediction for a request taken at the same edge, track
    // register writes, and end the run if nothing moves for too long.
    always @(posedge clk) begin
        lookup_outcome_t want;
        bit              moved;
        if (rst_n) begin
            moved = 1'b0;
            if (out_valid && !out_stall) begin
                moved = 1'b1;
                if (predicted_lookups.size() == 0) begin
                    report_mismatch("result arrived with no request outstanding");
                end
                else begin
                    want = predicted_lookups.pop_front();
                    if (hit !== want.hit)
                        report_mismatch($sformatf("hit %b, want %b", hit, want.hit));
                    if (hit_count !== want.hits)
                        report_mismatch($sformatf("hit_count %0d, want %0d",
                                                  hit_count, want.hits));
                    if (access_count !== want.accesses)
                        report_mismatch($sformatf("access_count %0d, want %0d",
                                                  access_count, want.accesses));
                end
                results_seen++;
                if (hit === 1'b1)
                    hits_observed++;
            end
            if (in_valid && !in_stall) begin
                moved = 1'b1;
                predicted_lookups.push_back(predict_access(address));
                accepted_items++;
            end
            if (cfg_write) begin
                case (cfg_index)
                    REG_BLOCK_OFFSET: shadow_offset = cfg_data;
                    REG_INDEX_BITS:   shadow_index  = cfg_data;
                    default:          ;
                endcase
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no request or result moved for %0d cycles", idle_cycles);
                $display("direct_mapped_cache_hit_counter_top_test: errors");
                $finish;
            end
        end
    end

    // Stimulus: directed corners, then phases of random traffic, each under
    // its own register setting, draining fully before each phase's register writes.
    initial begin
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] low_mask;
        logic [CFG_W-1:0]  cur_offset;
        logic [CFG_W-1:0]  cur_index;
        int unsigned       pick;
        int unsigned       tag_lo;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // The block holds in_stall through the line-store sweep; just queue.
        foreach (directed_addr[i]) begin
            pending_addr.push_back(directed_addr[i]);
            recent_addr.push_back(directed_addr[i]);
        end
        issued_items += NUM_DIRECTED;
        wait_for_drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < NUM_FIXED) begin
                cur_offset = sched_offset[p];
                cur_index  = sched_index[p];
            end
            else begin
                cur_offset = CFG_W'($urandom_range(15));
                cur_index  = CFG_W'($urandom_range(15));
            end
            write_reg(REG_BLOCK_OFFSET, cur_offset);
            write_reg(REG_INDEX_BITS, cur_index);
            // Drop junk into the unused indexes; the setting must survive it.
            if (p == 3) begin
                write_reg(REG_SPARE_LO, ~cur_offset);
                write_reg(REG_SPARE_HI, ~cur_index);
            end
            settings_run++;
            if (p == 2)
                long_hold_req = 1'b1;

            low_mask = (ADDR_W'(1) << cur_offset) - ADDR_W'(1);
            tag_lo   = cur_offset + ((cur_index > 10) ? 10 : cur_index);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                base = recent_addr[$urandom_range(recent_addr.size() - 1)];
                if (pick < 45) begin
                    // Same block as a recent access, any byte within it.
                    addr = (base & ~low_mask) | (ADDR_W'($urandom) & low_mask);
                end
                else if (pick < 65) begin
                    // Same line, different block: forces an eviction.
                    addr = base ^ (ADDR_W'(1) << $urandom_range(31, tag_lo));
                end
                else if (pick < 75) begin
                    // Back-to-back repeat exercises the same-line forwarding.
                    addr = recent_addr[recent_addr.size() - 1];
                end
                else begin
                    addr = ADDR_W'($urandom);
                end
                pending_addr.push_back(addr);
                recent_addr.push_back(addr);
                if (recent_addr.size() > HISTORY_DEPTH)
                    void'(recent_addr.pop_front());
            end
            issued_items += PHASE_ITEMS;
            wait_for_drain();
        end

        if (predicted_lookups.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", predicted_lookups.size()));

        $display("ran %0d requests under %0d register settings, with stalls on both sides",
                 accepted_items, settings_run);
        $display("checked %0d results, %0d of them hits", results_seen, hits_observed);
        if (error_count == 0)
            $display("direct_mapped_cache_hit_counter_top_test: clean");
        else
            $display("direct_mapped_cache_hit_counter_top_test: errors");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/dmc_pkg.sv
hw/rtl/dmc_front.sv
hw/rtl/dmc_queue.sv
hw/rtl/dmc_back.sv
hw/rtl/direct_mapped_cache_hit_counter_top.sv
tb/sv/direct_mapped_cache_hit_counter_top_test.sv
